// ===== hdl/sreo_pkg.sv =====
// ----------------------------------------------------------------------------
// Strided request end offset package
// Shared widths, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package sreo_pkg;

  localparam int unsigned MaxDimsDef    = 8;
  localparam int unsigned OffsetBitsDef = 64;

  localparam int unsigned StartW  = 63;
  localparam int unsigned CountW  = 62;
  localparam int unsigned StepW   = 62;
  localparam int unsigned ExtentW = 62;
  localparam int unsigned InnerW  = 62;
  localparam int unsigned BaseW   = 63;
  localparam int unsigned ElemW   = 32;
  localparam int unsigned RecW    = 63;
  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = WordW / 2;

  localparam int unsigned StartLsb  = 0;
  localparam int unsigned CountLsb  = StartLsb + StartW;
  localparam int unsigned StepLsb   = CountLsb + CountW;
  localparam int unsigned ExtentLsb = StepLsb + StepW;
  localparam int unsigned InnerLsb  = ExtentLsb + ExtentW;
  localparam int unsigned InFieldsW = InnerLsb + InnerW;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;

  localparam int unsigned UserHasCount = 0;
  localparam int unsigned UserHasStep  = 1;
  localparam int unsigned UserIsRead   = 2;
  localparam int unsigned UserIsScalar = 3;
  localparam int unsigned InUserW      = 4;

  localparam int unsigned OutDataW = WordW;
  localparam int unsigned OutUserW = 1;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [WordW-1:0] RecLimitNarrow = WordW'(64'h0000_0000_FFFF_FFFF);

  localparam logic [1:0] MulLastPhase = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VAR_BASE      = 3'd0,
    REG_ELEM_BYTES    = 3'd1,
    REG_RECORD_BYTES  = 3'd2,
    REG_RECORD_COUNT  = 3'd3,
    REG_IS_RECORD_VAR = 3'd4,
    REG_WIDE_FORMAT   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_CNT = 2'd0,
    MUL_WGT = 2'd1,
    MUL_OFF = 2'd2
  } mul_sel_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CNT  = 7'b0000010,
    ST_LAST = 7'b0000100,
    ST_WGT  = 7'b0001000,
    ST_OFF  = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_e;

  typedef struct packed {
    logic       load_item;
    logic       mul_en;
    mul_sel_e   mul_sel;
    logic [1:0] phase;
    logic       load_last;
    logic       load_weight;
    logic       accumulate;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic is_scalar;
    logic cnt_mul;
    logic need_wgt;
    logic is_last;
  } status_t;

endpackage

// ===== hdl/sreo_ctrl.sv =====
// ----------------------------------------------------------------------------
// Strided request end offset controller
// Sequences one dimension item through the shared multiplier and the result.
// ----------------------------------------------------------------------------
module sreo_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  sreo_pkg::status_t status_i,
  output sreo_pkg::cmd_t    cmd_o
);
  import sreo_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       phase_end;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign phase_end = (phase_q == MulLastPhase);

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_CNT;
    cmd_o.phase   = phase_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load_item = 1'b1;
          phase_d         = 2'd0;
          if (status_i.is_scalar) begin
            state_d = ST_EMIT;
          end else if (status_i.cnt_mul) begin
            state_d = ST_CNT;
          end else begin
            state_d = ST_LAST;
          end
        end
      end
      ST_CNT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CNT;
        phase_d       = phase_end ? 2'd0 : phase_q + 2'd1;
        if (phase_end) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        cmd_o.load_last = 1'b1;
        state_d         = status_i.need_wgt ? ST_WGT : ST_OFF;
      end
      ST_WGT: begin
        cmd_o.mul_en      = 1'b1;
        cmd_o.mul_sel     = MUL_WGT;
        cmd_o.load_weight = phase_end;
        phase_d           = phase_end ? 2'd0 : phase_q + 2'd1;
        if (phase_end) begin
          state_d = ST_OFF;
        end
      end
      ST_OFF: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_OFF;
        phase_d       = phase_end ? 2'd0 : phase_q + 2'd1;
        if (phase_end) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d          = status_i.is_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        phase_d = 2'd0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q != ST_IDLE)
    else $error("controller stayed idle after taking an item");

  a_mul_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OFF) && !phase_end |=> (state_q == ST_OFF))
    else $error("offset product left before its last partial product");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && out_free |=> m_axis_tvalid && (state_q == ST_IDLE))
    else $error("result not presented after emit");

endmodule

// ===== hdl/sreo_dpath.sv =====
// ----------------------------------------------------------------------------
// Strided request end offset datapath
// Item and configuration registers, shared 32x32 multiplier, bounds checks.
// ----------------------------------------------------------------------------
module sreo_dpath #(
  parameter int unsigned MaxDims    = sreo_pkg::MaxDimsDef,
  parameter int unsigned OffsetBits = sreo_pkg::OffsetBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [sreo_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sreo_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [sreo_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [sreo_pkg::InUserW-1:0]  s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic [sreo_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [sreo_pkg::OutUserW-1:0] m_axis_tuser,
  input  sreo_pkg::cmd_t                cmd_i,
  output sreo_pkg::status_t             status_o
);
  import sreo_pkg::*;

  localparam int unsigned DimW = $clog2(MaxDims + 1);
  localparam logic [DimW-1:0] DimMax = DimW'(MaxDims);

  logic [BaseW-1:0] var_base_q;
  logic [ElemW-1:0] elem_bytes_q;
  logic [RecW-1:0]  record_bytes_q;
  logic [RecW-1:0]  record_count_q;
  logic             is_record_var_q;
  logic             wide_format_q;

  logic [StartW-1:0]  start_q;
  logic [WordW-1:0]   cnt_m1_q;
  logic [StepW-1:0]   step_q;
  logic [ExtentW-1:0] extent_q;
  logic [InnerW-1:0]  inner_q;
  logic               has_count_q;
  logic               has_step_q;
  logic               is_read_q;
  logic               is_last_q;
  logic               is_scalar_q;

  logic [WordW-1:0]      acc_q, acc_d;
  logic [WordW-1:0]      last_q, last_d;
  logic [WordW-1:0]      weight_q;
  logic [OffsetBits-1:0] sum_q;
  logic                  err_q;
  logic [DimW-1:0]       dim_q;

  logic [WordW-1:0]      mul_a, mul_b, prod, addend, direct_weight;
  logic [HalfW-1:0]      mul_x, mul_y;
  logic                  record_dim, chk_err;
  logic [OffsetBits-1:0] res_sum;
  logic [OutDataW-1:0]   res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_base_q      <= '0;
      elem_bytes_q    <= ElemW'(1);
      record_bytes_q  <= '0;
      record_count_q  <= '0;
      is_record_var_q <= 1'b0;
      wide_format_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VAR_BASE:      var_base_q      <= cfg_data_i[BaseW-1:0];
        REG_ELEM_BYTES:    elem_bytes_q    <= cfg_data_i[ElemW-1:0];
        REG_RECORD_BYTES:  record_bytes_q  <= cfg_data_i[RecW-1:0];
        REG_RECORD_COUNT:  record_count_q  <= cfg_data_i[RecW-1:0];
        REG_IS_RECORD_VAR: is_record_var_q <= cfg_data_i[0];
        REG_WIDE_FORMAT:   wide_format_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      start_q     <= s_axis_tdata[StartLsb +: StartW];
      cnt_m1_q    <= WordW'(s_axis_tdata[CountLsb +: CountW]) - WordW'(1);
      step_q      <= s_axis_tdata[StepLsb +: StepW];
      extent_q    <= s_axis_tdata[ExtentLsb +: ExtentW];
      inner_q     <= s_axis_tdata[InnerLsb +: InnerW];
      has_count_q <= s_axis_tuser[UserHasCount];
      has_step_q  <= s_axis_tuser[UserHasStep];
      is_read_q   <= s_axis_tuser[UserIsRead];
      is_scalar_q <= s_axis_tuser[UserIsScalar];
      is_last_q   <= s_axis_tlast;
    end
  end

  assign record_dim = (dim_q == '0) && is_record_var_q;

  // The controller reads the item kind only while it takes an item.
  always_comb begin
    status_o.is_scalar = s_axis_tuser[UserIsScalar];
    status_o.cnt_mul   = s_axis_tuser[UserHasCount] && s_axis_tuser[UserHasStep];
    status_o.need_wgt  = !record_dim && !is_last_q;
    status_o.is_last   = is_last_q;
  end

  // One 32x32 partial product per phase; the upper cross terms only reach
  // the high half of the wrapped 64-bit product.
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_CNT: begin
        mul_a = cnt_m1_q;
        mul_b = WordW'(step_q);
      end
      MUL_WGT: begin
        mul_a = WordW'(inner_q);
        mul_b = WordW'(elem_bytes_q);
      end
      MUL_OFF: begin
        mul_a = last_q;
        mul_b = weight_q;
      end
      default: begin
        mul_a = last_q;
        mul_b = weight_q;
      end
    endcase
    mul_x  = (cmd_i.phase == MulLastPhase) ? mul_a[WordW-1:HalfW] : mul_a[HalfW-1:0];
    mul_y  = (cmd_i.phase == 2'd1) ? mul_b[WordW-1:HalfW] : mul_b[HalfW-1:0];
    prod   = WordW'(mul_x) * WordW'(mul_y);
    addend = (cmd_i.phase == 2'd0) ? prod : {prod[HalfW-1:0], {HalfW{1'b0}}};
    acc_d  = ((cmd_i.phase == 2'd0) ? '0 : acc_q) + addend;
  end

  always_comb begin
    last_d = WordW'($signed(start_q));
    if (has_count_q) begin
      last_d = last_d + (has_step_q ? acc_q : cnt_m1_q);
    end
    direct_weight = record_dim ? WordW'(record_bytes_q) : WordW'(elem_bytes_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.load_last) begin
      last_q <= last_d;
    end
    if (cmd_i.load_last && !status_o.need_wgt) begin
      weight_q <= direct_weight;
    end else if (cmd_i.load_weight) begin
      weight_q <= acc_d;
    end
  end

  always_comb begin
    if (record_dim) begin
      chk_err = (!wide_format_q && ($signed(last_q) > $signed(RecLimitNarrow))) ||
                (is_read_q && !($signed(last_q) < $signed(WordW'(record_count_q))));
    end else begin
      chk_err = last_q[WordW-1] || !($signed(last_q) < $signed(WordW'(extent_q)));
    end
  end

  always_comb begin
    if (is_scalar_q) begin
      res_sum  = OffsetBits'(WordW'(var_base_q) + WordW'(elem_bytes_q));
      res_data = OutDataW'($signed(res_sum));
    end else begin
      res_sum  = OffsetBits'(WordW'(var_base_q)) + sum_q;
      res_data = err_q ? '0 : OutDataW'($signed(res_sum));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      err_q <= 1'b0;
      dim_q <= '0;
    end else if (cmd_i.emit) begin
      sum_q <= '0;
      err_q <= 1'b0;
      dim_q <= '0;
    end else if (cmd_i.accumulate) begin
      sum_q <= sum_q + acc_q[OffsetBits-1:0];
      err_q <= err_q || chk_err;
      if (dim_q != DimMax) begin
        dim_q <= dim_q + DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_axis_tdata    <= res_data;
      m_axis_tuser[0] <= err_q && !is_scalar_q;
    end
  end

endmodule

// ===== hdl/strided_request_end_offset_unit.sv =====
// ----------------------------------------------------------------------------
// Strided request end offset unit
// Takes one item per dimension of a strided request and returns the byte
// offset of the last element touched, with a bounds status.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                     Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata, tuser, tlast
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata, tuser
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// The single 32x32 multiplier builds each wrapped 64-bit product from three
// partial products and serves up to three products per item.
// The next item is taken only after the current one is done; a result waiting
// in the output register stalls a following request only at its own result.
// Reset clears all control state and loads the register defaults.
module strided_request_end_offset_unit #(
  parameter int unsigned MaxDims    = sreo_pkg::MaxDimsDef,
  parameter int unsigned OffsetBits = sreo_pkg::OffsetBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sreo_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sreo_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_index, elem_count, step, extent, inner_elems, one zero pad bit
  input  logic [sreo_pkg::InDataW-1:0]  s_axis_tdata,
  // has_count, has_step, is_read, is_scalar
  input  logic [sreo_pkg::InUserW-1:0]  s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // end_offset
  output logic [sreo_pkg::OutDataW-1:0] m_axis_tdata,
  // status
  output logic [sreo_pkg::OutUserW-1:0] m_axis_tuser
);
  import sreo_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  sreo_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  sreo_dpath #(
    .MaxDims    (MaxDims),
    .OffsetBits (OffsetBits)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

// ===== verif/strided_request_end_offset_unit_test.sv =====
// ----------------------------------------------------------------------------
// Strided request end offset unit testbench
// Streams dimension items into the unit under several register settings and
// checks every end offset and status against a cycle-free predictor or, for
// typed table rows, a hand-written value. Hand-picked rows run first; random
// whole requests, scalars and noise follow, with random stalls on both streams and one long output stall.
// ----------------------------------------------------------------------------
module strided_request_end_offset_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sreo_pkg::*;

  localparam int F_CNT  = 1;
  localparam int F_STP  = 2;
  localparam int F_RD   = 4;
  localparam int F_LAST = 8;
  localparam int F_SCL  = 16;

  localparam logic [StartW-1:0]  SMax  = 63'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [StartW-1:0]  SMin  = 63'h4000_0000_0000_0000;
  localparam logic [StartW-1:0]  SNeg1 = '1;
  localparam logic [CountW-1:0]  F62   = '1;
  localparam logic [WordW-1:0]   NarrowRecMax = 64'h0000_0000_FFFF_FFFF;
  localparam logic [WordW-1:0]   Lim62 = 64'h4000_0000_0000_0000;
  localparam int SettleCycles = 24;
  localparam int HoldCycles   = 400;
  localparam int PhaseItems   = 88;
  localparam int NumPhases    = 8;

  typedef struct {
    logic [StartW-1:0]  start;
    logic [CountW-1:0]  cnt;
    logic [StepW-1:0]   stp;
    logic [ExtentW-1:0] ext;
    logic [InnerW-1:0]  inner;
    logic has_cnt;
    logic has_stp;
    logic rd;
    logic last;
    logic scalar;
  } dim_item_t;

  typedef struct {
    logic [WordW-1:0] offset;
    logic             status;
  } end_res_t;

  typedef struct {
    dim_item_t it;
    bit        typed;
    end_res_t  res;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  strided_request_end_offset_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Register copy and request state of the predictor.
  logic [BaseW-1:0] c_base;
  logic [ElemW-1:0] c_elem;
  logic [RecW-1:0]  c_rbytes;
  logic [RecW-1:0]  c_rcount;
  logic             c_isrec;
  logic             c_wide;
  logic [WordW-1:0] acc_sum;
  int unsigned      dim_idx;
  logic             req_bad;

  end_res_t end_q[$];
  int n_errors;
  int n_sent;
  int n_results;
  bit calm;
  bit held;

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_below(logic [63:0] n);
    return (n == 0) ? 64'd0 : rand64() % n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < 200) $display("mismatch at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  function automatic void apply_reg(cfg_reg_e idx, logic [63:0] d);
    case (idx)
      REG_VAR_BASE:      c_base   = d[BaseW-1:0];
      REG_ELEM_BYTES:    c_elem   = d[ElemW-1:0];
      REG_RECORD_BYTES:  c_rbytes = d[RecW-1:0];
      REG_RECORD_COUNT:  c_rcount = d[RecW-1:0];
      REG_IS_RECORD_VAR: c_isrec  = d[0];
      REG_WIDE_FORMAT:   c_wide   = d[0];
      default: ;
    endcase
  endfunction

  function automatic bit predict_end(input dim_item_t it, output end_res_t res);
    logic [WordW-1:0] start;
    logic [WordW-1:0] last;
    logic [WordW-1:0] weight;
    logic [WordW-1:0] cnt64;
    logic [WordW-1:0] stp64;
    logic [WordW-1:0] elem64;
    bit rec;
    res.offset = '0;
    res.status = 1'b0;
    elem64 = {32'b0, c_elem};
    if (it.scalar) begin
      acc_sum = '0;
      dim_idx = 0;
      req_bad = 1'b0;
      res.offset = {1'b0, c_base} + elem64;
      return 1;
    end
    start = {it.start[StartW-1], it.start};
    cnt64 = {2'b00, it.cnt};
    stp64 = {2'b00, it.stp};
    if (!it.has_cnt) last = start;
    else if (it.has_stp) last = start + (cnt64 - 64'd1) * stp64;
    else last = start + cnt64 - 64'd1;
    rec = (dim_idx == 0) && c_isrec;
    if (rec) begin
      if (!c_wide && $signed(NarrowRecMax) < $signed(last)) req_bad = 1'b1;
      if (it.rd && !($signed(last) < $signed({1'b0, c_rcount}))) req_bad = 1'b1;
      weight = {1'b0, c_rbytes};
    end else begin
      if ($signed(last) < 0 || !($signed(last) < $signed({2'b00, it.ext}))) req_bad = 1'b1;
      weight = it.last ? elem64 : {2'b00, it.inner} * elem64;
    end
    acc_sum = acc_sum + last * weight;
    if (dim_idx < MaxDimsDef) dim_idx++;
    if (!it.last) return 0;
    res.offset = req_bad ? '0 : {1'b0, c_base} + acc_sum;
    res.status = req_bad;
    acc_sum = '0;
    dim_idx = 0;
    req_bad = 1'b0;
    return 1;
  endfunction

  function automatic dir_row_t mk_row(logic [StartW-1:0] s, logic [CountW-1:0] c,
                                      logic [StepW-1:0] p, logic [ExtentW-1:0] x,
                                      logic [InnerW-1:0] n, int fl, bit typed,
                                      logic [WordW-1:0] off, logic st);
    dir_row_t r;
    r.it.start   = s;
    r.it.cnt     = c;
    r.it.stp     = p;
    r.it.ext     = x;
    r.it.inner   = n;
    r.it.has_cnt = (fl & F_CNT) != 0;
    r.it.has_stp = (fl & F_STP) != 0;
    r.it.rd      = (fl & F_RD) != 0;
    r.it.last    = (fl & F_LAST) != 0;
    r.it.scalar  = (fl & F_SCL) != 0;
    r.typed      = typed;
    r.res.offset = off;
    r.res.status = st;
    return r;
  endfunction

  // Builds one dimension item whose last index lands inside the bounds, or
  // just outside them when bad is set. Ignored fields keep random content.
  function automatic dim_item_t make_dim(bit rec, bit last, bit bad, bit rd);
    dim_item_t it;
    logic [63:0] hi;
    logic [63:0] tgt;
    logic [63:0] c;
    logic [63:0] p;
    logic [63:0] st;
    logic [63:0] q;
    int m;
    bit force16;
    it.start   = StartW'(rand64());
    it.cnt     = CountW'(rand64());
    it.stp     = StepW'(rand64());
    it.ext     = ExtentW'(rand64());
    it.inner   = ($urandom_range(0, 9) < 7) ? InnerW'($urandom_range(0, 100))
                                            : InnerW'(rand64());
    it.has_cnt = 1'($urandom);
    it.has_stp = 1'($urandom);
    it.rd      = rd;
    it.last    = last;
    it.scalar  = 1'b0;
    force16    = 0;
    if (rec) begin
      hi = c_wide ? Lim62 : 64'h1_0000_0000;
      if (rd && {1'b0, c_rcount} < hi) hi = {1'b0, c_rcount};
    end else begin
      case ($urandom_range(0, 9))
        0:       it.ext = '0;
        1, 2:    it.ext = ExtentW'(rand64());
        default: it.ext = ExtentW'($urandom_range(1, 1000));
      endcase
      hi = {2'b00, it.ext};
    end
    if (hi == 0) bad = 1;
    if (bad) begin
      if (!rec && $urandom_range(0, 1)) tgt = -64'd1 - 64'($urandom_range(0, 3));
      else tgt = hi + 64'($urandom_range(0, 3));
    end else if ($urandom_range(0, 1)) begin
      tgt = hi - 64'd1 - rand_below((hi < 4) ? hi : 64'd4);
    end else begin
      tgt = rand_below((hi < 1000) ? hi : 64'd1000);
    end
    m = $urandom_range(0, 3);
    if ($signed(tgt) < 0) begin
      m = 0;
    end else if (tgt >= Lim62) begin
      m = 1;
      force16 = 1;
    end else if (m == 3 && tgt > Lim62 - 64) begin
      m = 0;
    end
    case (m)
      0: begin
        it.has_cnt = 1'b0;
        st = tgt;
      end
      1: begin
        it.has_cnt = 1'b1;
        it.has_stp = 1'b0;
        c = force16 ? 64'd16 : 64'd1 + rand_below((tgt < 64'hFFFFF) ? tgt + 1 : 64'h100000);
        st = tgt - c + 64'd1;
        it.cnt = c[CountW-1:0];
      end
      2: begin
        it.has_cnt = 1'b1;
        it.has_stp = 1'b1;
        p = ($urandom_range(0, 19) == 0) ? (rand64() >> 2) : 64'($urandom_range(1, 16));
        if (p == 0) p = 64'd1;
        q = tgt / p;
        c = 64'd1 + rand_below((q < 64'hFFFFF) ? q + 1 : 64'h100000);
        st = tgt - (c - 64'd1) * p;
        it.cnt = c[CountW-1:0];
        it.stp = p[StepW-1:0];
      end
      default: begin
        it.has_cnt = 1'b1;
        it.cnt = '0;
        if (it.has_stp) begin
          p = 64'($urandom_range(1, 16));
          it.stp = p[StepW-1:0];
          st = tgt + p;
        end else begin
          st = tgt + 64'd1;
        end
      end
    endcase
    it.start = st[StartW-1:0];
    return it;
  endfunction

  task automatic send_item(input dim_item_t it, input bit typed, input end_res_t typed_res);
    int gap;
    logic [InUserW-1:0] u;
    end_res_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    u = '0;
    u[UserHasCount] = it.has_cnt;
    u[UserHasStep]  = it.has_stp;
    u[UserIsRead]   = it.rd;
    u[UserIsScalar] = it.scalar;
    s_axis_tdata  = InDataW'({1'b0, it.inner, it.ext, it.stp, it.cnt, it.start});
    s_axis_tuser  = u;
    s_axis_tlast  = it.last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    if (predict_end(it, res)) end_q.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic send_request();
    int r;
    int nd;
    int bad_pos;
    bit rd;
    dim_item_t it;
    end_res_t none;
    none = '{default: '0};
    r  = $urandom_range(0, 99);
    rd = 1'($urandom);
    if (r < 6) begin
      it = make_dim(0, 1'($urandom), 0, rd);
      it.scalar = 1'b1;
      send_item(it, 0, none);
    end else if (r < 82) begin
      nd = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 11) : $urandom_range(1, 4);
      bad_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nd - 1) : -1;
      for (int d = 0; d < nd; d++) begin
        it = make_dim(d == 0 && c_isrec, d == nd - 1, d == bad_pos, rd);
        if (d < nd - 1 && $urandom_range(0, 32) == 0) begin
          it.scalar = 1'b1;
          send_item(it, 0, none);
          break;
        end
        send_item(it, 0, none);
      end
    end else begin
      nd = $urandom_range(1, 4);
      for (int d = 0; d < nd; d++) begin
        it.start   = StartW'(rand64());
        it.cnt     = CountW'(rand64());
        it.stp     = StepW'(rand64());
        it.ext     = ExtentW'(rand64());
        it.inner   = InnerW'(rand64());
        it.has_cnt = 1'($urandom);
        it.has_stp = 1'($urandom);
        it.rd      = 1'($urandom);
        it.last    = (d == nd - 1) || ($urandom_range(0, 7) == 0);
        it.scalar  = ($urandom_range(0, 15) == 0);
        send_item(it, 0, none);
      end
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] v, input int w);
    logic [63:0] mask;
    logic [63:0] d;
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    d = (rand64() & ~mask) | (v & mask);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(input int ph);
    logic [63:0] base;
    logic [63:0] elem;
    logic [63:0] rb;
    logic [63:0] rc;
    bit isrec;
    bit wide;
    case (ph)
      0: begin
        base = 0; elem = 1; rb = 0; rc = 0; isrec = 0; wide = 0;
      end
      1: begin
        base = 64'h7FFF_FFFF_FFFF_FFFF; elem = 64'hFFFF_FFFF;
        rb = 64'h7FFF_FFFF_FFFF_FFFF; rc = 64'h7FFF_FFFF_FFFF_FFFF; isrec = 1; wide = 1;
      end
      2: begin
        base = rand64() >> 1; elem = 64'($urandom_range(1, 16));
        rb = 64'($urandom_range(0, 4096)); rc = 64'($urandom_range(0, 50));
        isrec = 1; wide = 0;
      end
      3: begin
        base = 64'($urandom_range(0, 1 << 20)); elem = 64'($urandom_range(1, 8));
        rb = 64'($urandom_range(1, 1 << 16)); rc = 64'h1_0000_0010; isrec = 1; wide = 0;
      end
      4: begin
        base = 64'($urandom); elem = 64'hFFFF_FFFF; rb = rand64() >> 1; rc = 0;
        isrec = 1; wide = 1;
      end
      default: begin
        base = $urandom_range(0, 1) ? rand64() >> 1 : 64'($urandom_range(0, 4096));
        elem = $urandom_range(0, 1) ? 64'($urandom) : 64'($urandom_range(1, 16));
        if (elem == 0) elem = 1;
        rb = $urandom_range(0, 1) ? rand64() >> 1 : 64'($urandom_range(0, 4096));
        rc = $urandom_range(0, 1) ? rand64() >> 1 : 64'($urandom_range(0, 2000));
        isrec = 1'($urandom);
        wide = 1'($urandom);
      end
    endcase
    write_reg(REG_VAR_BASE, base, BaseW);
    write_reg(REG_ELEM_BYTES, elem, ElemW);
    write_reg(REG_RECORD_BYTES, rb, RecW);
    write_reg(REG_RECORD_COUNT, rc, RecW);
    write_reg(REG_IS_RECORD_VAR, 64'(isrec), 1);
    write_reg(REG_WIDE_FORMAT, 64'(wide), 1);
  endtask

  task automatic wait_idle();
    while (end_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    end_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (end_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result offset %h status %0d",
                                  m_axis_tdata, m_axis_tuser[0]));
      end else begin
        e = end_q.pop_front();
        if (m_axis_tdata !== e.offset)
          report_mismatch($sformatf("end_offset %h, expected %h", m_axis_tdata, e.offset));
        if (m_axis_tuser[0] !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser[0], e.status));
      end
    end
  end

  int stall_left;
  initial begin
    m_axis_tready = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && n_results >= 60) begin
        held = 1;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    int target;
    int waited;
    n_errors = 0;
    n_sent = 0;
    n_results = 0;
    calm = 0;
    held = 0;
    c_base = '0;
    c_elem = 32'd1;
    c_rbytes = '0;
    c_rcount = '0;
    c_isrec = 1'b0;
    c_wide = 1'b0;
    acc_sum = '0;
    dim_idx = 0;
    req_bad = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    rows.push_back(mk_row(0, 0, 0, 0, 0, F_SCL, 1, 64'd1, 0));
    rows.push_back(mk_row(0, 0, 0, 1, 0, F_LAST, 1, 64'd0, 0));
    rows.push_back(mk_row(SNeg1, 0, 0, F62, 0, F_LAST | F_RD, 1, 64'd0, 1));
    rows.push_back(mk_row(SMax, 0, 0, F62, 0, F_LAST, 1, 64'd0, 1));
    rows.push_back(mk_row(SMax - 1, 0, 0, F62, F62, F_LAST, 1, 64'h3FFF_FFFF_FFFF_FFFE, 0));
    rows.push_back(mk_row(SMin, F62, F62, F62, F62, F_LAST | F_STP, 1, 64'd0, 1));
    rows.push_back(mk_row(0, 0, 0, 0, 0, F_LAST, 1, 64'd0, 1));
    rows.push_back(mk_row(5, 0, 0, 10, 0, F_LAST | F_CNT, 0, 0, 0));
    rows.push_back(mk_row(5, 0, 3, 10, 0, F_LAST | F_CNT | F_STP, 0, 0, 0));
    rows.push_back(mk_row(0, F62, F62, F62, F62, F_LAST | F_CNT | F_STP, 0, 0, 0));
    rows.push_back(mk_row(1, 2, F62, 4, 12, F_CNT, 0, 0, 0));
    rows.push_back(mk_row(0, 3, 2, 6, 2, F_CNT | F_STP, 0, 0, 0));
    rows.push_back(mk_row(2, 1, 0, 3, F62, F_LAST | F_CNT, 0, 0, 0));
    rows.push_back(mk_row(2, 0, 0, 3, F62, F_RD, 0, 0, 0));
    rows.push_back(mk_row(SNeg1, F62, F62, 0, F62, F_SCL | F_LAST | F_CNT | F_STP | F_RD,
                          1, 64'd1, 0));
    rows.push_back(mk_row(7, 0, 0, 3, 1, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, 1, 0, F_LAST, 1, 64'd0, 1));
    for (int i = 0; i < 9; i++) rows.push_back(mk_row(1, 0, 0, 2, 3, (i % 2) ? F_RD : 0, 0, 0, 0));
    rows.push_back(mk_row(0, 2, 1, 2, 0, F_LAST | F_CNT, 0, 0, 0));
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

    for (int ph = 0; ph < NumPhases; ph++) begin
      s_axis_tvalid = 1'b0;
      wait_idle();
      set_config(ph);
      calm = (ph == 5);
      target = n_sent + PhaseItems;
      while (n_sent < target) send_request();
    end
    s_axis_tvalid = 1'b0;
    calm = 0;

    waited = 0;
    while (end_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (end_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", end_q.size()));
    repeat (SettleCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS strided_request_end_offset_unit");
    end else begin
      $display("FAIL strided_request_end_offset_unit");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL strided_request_end_offset_unit");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sreo_pkg.sv
hdl/sreo_ctrl.sv
hdl/sreo_dpath.sv
hdl/strided_request_end_offset_unit.sv
verif/strided_request_end_offset_unit_test.sv
